// ----- hw/rtl/rfpc_pkg.sv -----
// ----------------------------------------------------------------------------
// rfpc_pkg
// Microcode types, step addresses and control store for the fraction reducer.
// ----------------------------------------------------------------------------
package rfpc_pkg;

    localparam int PC_W = 5;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT,
        OP_DIV_GCD,
        OP_GCD_SWAP,
        OP_DIV_AN,
        OP_SET_AN,
        OP_DIV_AD,
        OP_SET_AD,
        OP_TRIAL_INIT,
        OP_DIV_TRIAL,
        OP_NEXT_I,
        OP_CLR_PRIME,
        OP_NEXT_PASS,
        OP_OUT
    } op_t;

    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_IN_IDLE,
        COND_BYPASS,
        COND_Y_ZERO,
        COND_DIV_BUSY,
        COND_M_LT2,
        COND_SQ_GT_M,
        COND_REM_NZ,
        COND_PASS_SET,
        COND_OUT_FULL
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctl_word_t;

    // step addresses
    localparam logic [PC_W-1:0] ST_WAIT       = 5'd0;
    localparam logic [PC_W-1:0] ST_CHECK      = 5'd1;
    localparam logic [PC_W-1:0] ST_GCD_TEST   = 5'd2;
    localparam logic [PC_W-1:0] ST_GCD_START  = 5'd3;
    localparam logic [PC_W-1:0] ST_GCD_WAIT   = 5'd4;
    localparam logic [PC_W-1:0] ST_GCD_SWAP   = 5'd5;
    localparam logic [PC_W-1:0] ST_AN_START   = 5'd6;
    localparam logic [PC_W-1:0] ST_AN_WAIT    = 5'd7;
    localparam logic [PC_W-1:0] ST_AN_SET     = 5'd8;
    localparam logic [PC_W-1:0] ST_AD_START   = 5'd9;
    localparam logic [PC_W-1:0] ST_AD_WAIT    = 5'd10;
    localparam logic [PC_W-1:0] ST_AD_SET     = 5'd11;
    localparam logic [PC_W-1:0] ST_TR_INIT    = 5'd12;
    localparam logic [PC_W-1:0] ST_TR_SMALL   = 5'd13;
    localparam logic [PC_W-1:0] ST_TR_BOUND   = 5'd14;
    localparam logic [PC_W-1:0] ST_TR_START   = 5'd15;
    localparam logic [PC_W-1:0] ST_TR_WAIT    = 5'd16;
    localparam logic [PC_W-1:0] ST_TR_NEXT    = 5'd17;
    localparam logic [PC_W-1:0] ST_NOT_PRIME  = 5'd18;
    localparam logic [PC_W-1:0] ST_PASS_DONE  = 5'd19;
    localparam logic [PC_W-1:0] ST_PASS_LOOP  = 5'd20;
    localparam logic [PC_W-1:0] ST_OUT        = 5'd21;
    localparam logic [PC_W-1:0] ST_RETURN     = 5'd22;
    localparam logic [PC_W-1:0] ST_LAST       = ST_RETURN;

    // control store: when cond holds jump to target, else fall through
    function automatic ctl_word_t rom_word(input logic [PC_W-1:0] pc);
        ctl_word_t w;
        w = '{op: OP_NONE, cond: COND_ALWAYS, target: ST_WAIT};
        case (pc)
            ST_WAIT:      w = '{op: OP_LOAD,       cond: COND_IN_IDLE,  target: ST_WAIT};
            ST_CHECK:     w = '{op: OP_INIT,       cond: COND_BYPASS,   target: ST_OUT};
            ST_GCD_TEST:  w = '{op: OP_NONE,       cond: COND_Y_ZERO,   target: ST_AN_START};
            ST_GCD_START: w = '{op: OP_DIV_GCD,    cond: COND_NEVER,    target: ST_WAIT};
            ST_GCD_WAIT:  w = '{op: OP_NONE,       cond: COND_DIV_BUSY, target: ST_GCD_WAIT};
            ST_GCD_SWAP:  w = '{op: OP_GCD_SWAP,   cond: COND_ALWAYS,   target: ST_GCD_TEST};
            ST_AN_START:  w = '{op: OP_DIV_AN,     cond: COND_NEVER,    target: ST_WAIT};
            ST_AN_WAIT:   w = '{op: OP_NONE,       cond: COND_DIV_BUSY, target: ST_AN_WAIT};
            ST_AN_SET:    w = '{op: OP_SET_AN,     cond: COND_NEVER,    target: ST_WAIT};
            ST_AD_START:  w = '{op: OP_DIV_AD,     cond: COND_NEVER,    target: ST_WAIT};
            ST_AD_WAIT:   w = '{op: OP_NONE,       cond: COND_DIV_BUSY, target: ST_AD_WAIT};
            ST_AD_SET:    w = '{op: OP_SET_AD,     cond: COND_NEVER,    target: ST_WAIT};
            ST_TR_INIT:   w = '{op: OP_TRIAL_INIT, cond: COND_NEVER,    target: ST_WAIT};
            ST_TR_SMALL:  w = '{op: OP_NONE,       cond: COND_M_LT2,    target: ST_NOT_PRIME};
            ST_TR_BOUND:  w = '{op: OP_NONE,       cond: COND_SQ_GT_M,  target: ST_PASS_DONE};
            ST_TR_START:  w = '{op: OP_DIV_TRIAL,  cond: COND_NEVER,    target: ST_WAIT};
            ST_TR_WAIT:   w = '{op: OP_NONE,       cond: COND_DIV_BUSY, target: ST_TR_WAIT};
            ST_TR_NEXT:   w = '{op: OP_NEXT_I,     cond: COND_REM_NZ,   target: ST_TR_BOUND};
            ST_NOT_PRIME: w = '{op: OP_CLR_PRIME,  cond: COND_ALWAYS,   target: ST_OUT};
            ST_PASS_DONE: w = '{op: OP_NEXT_PASS,  cond: COND_PASS_SET, target: ST_OUT};
            ST_PASS_LOOP: w = '{op: OP_NONE,       cond: COND_ALWAYS,   target: ST_TR_INIT};
            ST_OUT:       w = '{op: OP_OUT,        cond: COND_OUT_FULL, target: ST_OUT};
            ST_RETURN:    w = '{op: OP_NONE,       cond: COND_ALWAYS,   target: ST_WAIT};
            default:      w = '{op: OP_NONE,       cond: COND_ALWAYS,   target: ST_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ----- hw/rtl/reduce_fraction_prime_check.sv -----
// ----------------------------------------------------------------------------
// reduce_fraction_prime_check
// Reduces a signed fraction to lowest terms and tests both terms for primality.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one fraction per word (numerator, denominator). m_axis
//   returns one word per input: the reduced fraction in tdata, and in tuser
//   the both-prime flag and the invalid (zero denominator) flag.
//   A microcoded sequencer steps through gcd, the two divisions by the gcd and
//   trial division, all on one shared restoring divider. A zero numerator or
//   denominator skips straight from the check step to the output step;
//   otherwise the gcd runs one division per remainder step, then the two
//   reductions, then one division per trial divisor (2, then odd numbers up
//   to the square root). One item is in work at a time; after the result is
//   loaded the sequencer returns to the wait step to take the next word.
//   The result sits in an output register: a stalled receiver does not stop
//   the next item from being accepted and worked on, only its hand-off.
//   Reset clears the sequencer to its wait step and empties the output.
// ----------------------------------------------------------------------------
module reduce_fraction_prime_check #(
    parameter  int VALUE_WIDTH = 16,
    localparam int TDATA_WIDTH = ((2 * VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TDATA_WIDTH-1:0] s_axis_tdata,  // numerator, denominator
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDATA_WIDTH-1:0] m_axis_tdata,  // reduced_numerator, reduced_denominator
    output logic [1:0]             m_axis_tuser   // both_prime, invalid
);

    import rfpc_pkg::*;

    localparam int W    = VALUE_WIDTH;
    localparam int SQ_W = VALUE_WIDTH + 2;

    ctl_word_t ctl;

    logic [PC_W-1:0] pc_reg, pc_next;
    logic [W-1:0]    num_reg, num_next;
    logic [W-1:0]    den_reg, den_next;
    logic [W-1:0]    an_reg, an_next;
    logic [W-1:0]    ad_reg, ad_next;
    logic [W-1:0]    x_reg, x_next;
    logic [W-1:0]    y_reg, y_next;
    logic [W-1:0]    m_reg, m_next;
    logic [W-1:0]    i_reg, i_next;
    logic [SQ_W-1:0] sq_reg, sq_next;
    logic            neg_reg, neg_next;
    logic            prime_reg, prime_next;
    logic            pass_reg, pass_next;

    logic            out_valid_reg, out_valid_next;
    logic [W-1:0]    out_num_reg, out_num_next;
    logic [W-1:0]    out_den_reg, out_den_next;
    logic            out_prime_reg, out_prime_next;
    logic            out_inv_reg, out_inv_next;

    logic [W-1:0]    in_num, in_den, mag_num, mag_den;
    logic            in_take, bypass, out_full, out_load, jump;
    logic [SQ_W-1:0] sq_step;

    logic            div_start, div_busy;
    logic [W-1:0]    div_dividend, div_divisor, div_quo, div_rem;

    assign in_num  = s_axis_tdata[W-1:0];
    assign in_den  = s_axis_tdata[2*W-1:W];
    assign mag_num = in_num[W-1] ? W'(-in_num) : in_num;
    assign mag_den = in_den[W-1] ? W'(-in_den) : in_den;

    assign ctl           = rom_word(pc_reg);
    assign s_axis_tready = ctl.op == OP_LOAD;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign bypass        = (num_reg == '0) || (den_reg == '0);
    assign out_full      = out_valid_reg && !m_axis_tready;
    assign out_load      = (ctl.op == OP_OUT) && !out_full;

    // increment of i squared as i steps to the next candidate: 2 -> 3, then by two
    assign sq_step = (i_reg == W'(2)) ? ({2'b00, i_reg} << 1) + SQ_W'(1)
                                      : ({2'b00, i_reg} << 2) + SQ_W'(4);

    rfpc_div #(
        .WIDTH(W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = x_reg;
        div_divisor  = y_reg;
        case (ctl.op)
            OP_DIV_GCD:
            begin
                div_start = 1'b1;
            end
            OP_DIV_AN:
            begin
                div_start    = 1'b1;
                div_dividend = an_reg;
                div_divisor  = x_reg;
            end
            OP_DIV_AD:
            begin
                div_start    = 1'b1;
                div_dividend = ad_reg;
                div_divisor  = x_reg;
            end
            OP_DIV_TRIAL:
            begin
                div_start    = 1'b1;
                div_dividend = m_reg;
                div_divisor  = i_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (ctl.cond)
            COND_NEVER:    jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_IN_IDLE:  jump = !s_axis_tvalid;
            COND_BYPASS:   jump = bypass;
            COND_Y_ZERO:   jump = y_reg == '0;
            COND_DIV_BUSY: jump = div_busy;
            COND_M_LT2:    jump = m_reg < W'(2);
            COND_SQ_GT_M:  jump = sq_reg > {2'b00, m_reg};
            COND_REM_NZ:   jump = div_rem != '0;
            COND_PASS_SET: jump = pass_reg;
            COND_OUT_FULL: jump = out_full;
            default:       jump = 1'b0;
        endcase
        pc_next = jump ? ctl.target : pc_reg + 1'b1;
    end

    always_comb
    begin
        num_next   = num_reg;
        den_next   = den_reg;
        an_next    = an_reg;
        ad_next    = ad_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        m_next     = m_reg;
        i_next     = i_reg;
        sq_next    = sq_reg;
        neg_next   = neg_reg;
        prime_next = prime_reg;
        pass_next  = pass_reg;
        case (ctl.op)
            OP_LOAD:
            begin
                if (in_take)
                begin
                    num_next = in_num;
                    den_next = in_den;
                    an_next  = mag_num;
                    ad_next  = mag_den;
                    x_next   = mag_num;
                    y_next   = mag_den;
                    neg_next = in_num[W-1] ^ in_den[W-1];
                end
            end
            OP_INIT:
            begin
                prime_next = 1'b1;
                pass_next  = 1'b0;
            end
            OP_GCD_SWAP:
            begin
                x_next = y_reg;
                y_next = div_rem;
            end
            OP_SET_AN:
            begin
                an_next = div_quo;
            end
            OP_SET_AD:
            begin
                ad_next = div_quo;
            end
            OP_TRIAL_INIT:
            begin
                m_next  = pass_reg ? ad_reg : an_reg;
                i_next  = W'(2);
                sq_next = SQ_W'(4);
            end
            OP_NEXT_I:
            begin
                i_next  = (i_reg == W'(2)) ? W'(3) : i_reg + W'(2);
                sq_next = sq_reg + sq_step;
            end
            OP_CLR_PRIME:
            begin
                prime_next = 1'b0;
            end
            OP_NEXT_PASS:
            begin
                pass_next = 1'b1;
            end
            default:
            begin
                pass_next = pass_reg;
            end
        endcase
    end

    always_comb
    begin
        out_num_next   = out_num_reg;
        out_den_next   = out_den_reg;
        out_prime_next = out_prime_reg;
        out_inv_next   = out_inv_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            if (bypass)
            begin
                out_num_next   = num_reg;
                out_den_next   = den_reg;
                out_prime_next = 1'b0;
                out_inv_next   = den_reg == '0;
            end
            else
            begin
                out_num_next   = neg_reg ? W'(-an_reg) : an_reg;
                out_den_next   = ad_reg;
                out_prime_next = prime_reg;
                out_inv_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= ST_WAIT;
            out_valid_reg <= 1'b0;
            prime_reg     <= 1'b0;
            pass_reg      <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            prime_reg     <= prime_next;
            pass_reg      <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg       <= num_next;
        den_reg       <= den_next;
        an_reg        <= an_next;
        ad_reg        <= ad_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        m_reg         <= m_next;
        i_reg         <= i_next;
        sq_reg        <= sq_next;
        neg_reg       <= neg_next;
        out_num_reg   <= out_num_next;
        out_den_reg   <= out_den_next;
        out_prime_reg <= out_prime_next;
        out_inv_reg   <= out_inv_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_WIDTH'({out_den_reg, out_num_reg});
    assign m_axis_tuser  = {out_inv_reg, out_prime_reg};

    // divider is never restarted while a division is in flight
    a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // a waiting result is never overwritten
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !(out_valid_reg && !m_axis_tready))
        else $error("output word overwritten");

    // sequencer stays inside the program
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= ST_LAST)
        else $error("step counter out of program");

    // an invalid fraction is never flagged prime
    a_invalid_not_prime: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_inv_reg) |-> !out_prime_reg)
        else $error("invalid word flagged prime");

    // a word is taken only at the wait step, and work starts next cycle
    a_take_then_check: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> pc_reg == ST_CHECK)
        else $error("sequencer did not start after input word");

endmodule

// ----- hw/rtl/rfpc_div.sv -----
// ----------------------------------------------------------------------------
// rfpc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rfpc_div #(
    parameter int WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             busy,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dsr_reg, dsr_next;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[WIDTH-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_comb
    begin
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        if (start)
        begin
            cnt_next = CNT_W'(WIDTH);
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            quo_next = {quo_reg[WIDTH-2:0], fits};
            rem_next = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = cnt_reg != '0;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fraction reducer with primality flag.
// ----------------------------------------------------------------------------
// Each accepted input word is reduced in the bench with a gcd and trial
// division, and the expected word is queued. Output words are compared
// field by field in order. Stimulus starts with directed corner fractions:
// signs, zero terms, the most negative value and squares of primes. It then
// runs a random mix of raw words, small terms, scaled prime-rich fractions,
// large slow terms and zero terms. Both sides idle in random bursts but for
// a last phase. The receiver holds off once for a long stretch so that the
// block backs up, and the sender drains the block after it and at the end.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int VW             = 16;
    localparam int TDW            = 32;
    localparam int RX_HOLD_CYCLES = 10000;
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int N_DIRECTED     = 25;

    localparam int DIR_NUM [0:N_DIRECTED-1] = '{
        6, -6, 6, -6, 3, -3, 4, 25, 2, 2, 0, 0, 7, 0, -32768,
        1, 32767, -32767, 32749, -32768, 1, -32768, 16384, -32768, 17
    };
    localparam int DIR_DEN [0:N_DIRECTED-1] = '{
        8, 8, -8, -8, 5, 7, 9, 49, 3, 4, 5, -5, 0, 0, 0,
        1, 32767, 1, 32719, 1, -32768, -32768, -32768, 3, -32767
    };

    class fraction_scoreboard;
        typedef struct packed {
            logic [VW-1:0] rden;
            logic [VW-1:0] rnum;
            logic          invalid;
            logic          both_prime;
        } fraction_result_t;

        fraction_result_t reduced_q[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        function bit prime_by_trial(longint m);
            longint i;
            if (m < 2)
                return 1'b0;
            for (i = 2; i * i <= m; i++)
            begin
                if (m % i == 0)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_fraction(logic [VW-1:0] num, logic [VW-1:0] den);
            fraction_result_t r;
            longint n, d, an, ad, a, b, t, rn;
            n = longint'($signed(num));
            d = longint'($signed(den));
            r = '0;
            if (d == 0)
            begin
                r.rnum    = num;
                r.rden    = den;
                r.invalid = 1'b1;
            end
            else if (n == 0)
            begin
                r.rden = den;
            end
            else
            begin
                an = (n < 0) ? -n : n;
                ad = (d < 0) ? -d : d;
                a  = an;
                b  = ad;
                while (b != 0)
                begin
                    t = a % b;
                    a = b;
                    b = t;
                end
                an = an / a;
                ad = ad / a;
                rn = ((n < 0) != (d < 0)) ? -an : an;
                // magnitude 2^15 wraps back to the most negative value
                r.rnum       = rn[VW-1:0];
                r.rden       = ad[VW-1:0];
                r.both_prime = prime_by_trial(an) && prime_by_trial(ad);
            end
            reduced_q.push_back(r);
        endfunction

        function void report(string field, int expv, int actv);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, expv, actv);
        endfunction

        function void check_result(logic [TDW-1:0] data, logic [1:0] user);
            fraction_result_t e;
            if (reduced_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none, actual tdata %h tuser %b",
                         $time, data, user);
                return;
            end
            e = reduced_q.pop_front();
            if (data[VW-1:0] !== e.rnum)
                report("reduced_numerator", $signed(e.rnum), $signed(data[VW-1:0]));
            if (data[2*VW-1:VW] !== e.rden)
                report("reduced_denominator", $signed(e.rden), $signed(data[2*VW-1:VW]));
            if (user[0] !== e.both_prime)
                report("both_prime", e.both_prime, user[0]);
            if (user[1] !== e.invalid)
                report("invalid", e.invalid, user[1]);
        endfunction

        function int pending();
            return reduced_q.size();
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [TDW-1:0] s_axis_tdata;   // numerator, denominator
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [TDW-1:0] m_axis_tdata;   // reduced_numerator, reduced_denominator
    logic [1:0]     m_axis_tuser;   // both_prime, invalid

    fraction_scoreboard sb = new();
    bit no_idle     = 1'b0;
    bit rx_hold_req = 1'b0;
    int idle_cycles = 0;

    reduce_fraction_prime_check #(
        .VALUE_WIDTH(VW)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [VW-1:0] with_sign(int mag);
        logic [VW-1:0] v;
        v = VW'(mag);
        if ($urandom_range(0, 1) == 1)
            v = -v;
        return v;
    endfunction

    function automatic logic [TDW-1:0] pick_fraction();
        int sel, a, b, k;
        logic [VW-1:0] n, d;
        sel = $urandom_range(0, 99);
        if (sel < 55)
        begin
            n = VW'($urandom);
            d = VW'($urandom);
        end
        else if (sel < 70)
        begin
            n = with_sign($urandom_range(0, 40));
            d = with_sign($urandom_range(1, 40));
        end
        else if (sel < 85)
        begin
            // small terms scaled by a common factor, reduce to prime-rich pairs
            a = $urandom_range(1, 181);
            b = $urandom_range(1, 181);
            k = $urandom_range(1, 32767 / ((a > b) ? a : b));
            n = with_sign(a * k);
            d = with_sign(b * k);
        end
        else if (sel < 92)
        begin
            n = with_sign($urandom_range(1000, 32767));
            d = with_sign($urandom_range(32000, 32767));
        end
        else if (sel < 96)
        begin
            n = '0;
            d = VW'($urandom);
        end
        else
        begin
            n = VW'($urandom);
            d = '0;
        end
        return {d, n};
    endfunction

    task automatic offer_fraction(input logic [VW-1:0] num, input logic [VW-1:0] den,
                                  input bit allow_gap);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {den, num};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_fraction(num, den);
        if (allow_gap && !no_idle && $urandom_range(0, 2) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic offer_random(input int count, input bit allow_gap);
        logic [TDW-1:0] w;
        repeat (count)
        begin
            w = pick_fraction();
            offer_fraction(w[VW-1:0], w[TDW-1:VW], allow_gap);
        end
    endtask

    // receiver: random ready bursts, plus one long hold on request
    initial
    begin
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            else if (no_idle || $urandom_range(0, 3) != 0)
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            offer_fraction(VW'(DIR_NUM[i]), VW'(DIR_DEN[i]), 1'b1);

        offer_random(150, 1'b1);

        // stall the output while words keep coming so the block backs up
        rx_hold_req = 1'b1;
        offer_random(6, 1'b0);

        // drain completely before going on
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);

        offer_random(80, 1'b1);

        no_idle = 1'b1;
        offer_random(64, 1'b1);

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
